// ===== hdl/tlpd_pkg.sv =====
// ============================================================================
// tlpd_pkg
// Shared constants, codes and types of the trie prefix depth block.
// ============================================================================
`default_nettype none

package tlpd_pkg;

  // Default sizes
  localparam int DEF_MAX_STRINGS = 4096;
  localparam int DEF_LOG_LEVELS  = 12;
  localparam int DEF_ALPHABET    = 26;

  // Fixed field widths
  localparam int IDX_W    = 12;
  localparam int LETTER_W = 7;
  localparam int STAT_W   = 2;

  localparam logic [LETTER_W-1:0] LETTER_BASE = 7'h61;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDEFINED = 2'd2;

  // One result beat handed from the sequencer to the output stage
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  depth;
    logic [IDX_W-1:0]  index;
    logic [STAT_W-1:0] status;
  } tlpd_res_t;

endpackage

`default_nettype wire

// ===== hdl/tlpd_anc.sv =====
// ============================================================================
// tlpd_anc
// Ancestor table memory: one write and one read port, registered read.
// The root row reads as zero without ever being written.
// ============================================================================
`default_nettype none

module tlpd_anc
  import tlpd_pkg::*;
#(
  parameter int NW = 12,
  parameter int LW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [NW-1:0] wnode,
  input  wire logic [LW-1:0] wlvl,
  input  wire logic [NW-1:0] wdata,
  input  wire logic [NW-1:0] rnode,
  input  wire logic [LW-1:0] rlvl,
  output logic      [NW-1:0] rdata
);

  logic [NW-1:0] mem [0:(1<<(NW+LW))-1];
  logic [NW-1:0] q_r;
  logic          root_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wnode, wlvl}] <= wdata;
    end
    q_r    <= mem[{rnode, rlvl}];
    root_r <= (rnode == '0);
  end

  // The root is its own ancestor at every level.
  assign rdata = root_r ? '0 : q_r;

endmodule

`default_nettype wire

// ===== hdl/tlpd_ctrl.sv =====
// ============================================================================
// tlpd_ctrl
// Sequencer for inserts and queries, holding the string, depth, child and
// node information memories and driving the ancestor table.
// ============================================================================
`default_nettype none

module tlpd_ctrl
  import tlpd_pkg::*;
#(
  parameter int MAX_STRINGS = DEF_MAX_STRINGS,
  parameter int LOG_LEVELS  = DEF_LOG_LEVELS,
  parameter int ALPHABET    = DEF_ALPHABET
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     idle,
  input  wire logic                op,
  input  wire logic [IDX_W-1:0]    parent_string,
  input  wire logic [LETTER_W-1:0] letter,
  input  wire logic [IDX_W-1:0]    first_string,
  input  wire logic [IDX_W-1:0]    second_string,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output tlpd_res_t                res
);

  localparam int NW  = $clog2(MAX_STRINGS);
  localparam int CW  = NW + 1;
  localparam int XW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int AW  = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int LW  = (LOG_LEVELS > 2) ? $clog2(LOG_LEVELS) : 1;
  localparam int LCW = $clog2(LOG_LEVELS + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] I_S2N    = 5'd1;
  localparam logic [4:0] I_CHILD  = 5'd2;
  localparam logic [4:0] I_INFO   = 5'd3;
  localparam logic [4:0] I_NEW    = 5'd4;
  localparam logic [4:0] I_FRD    = 5'd5;
  localparam logic [4:0] I_FWR    = 5'd6;
  localparam logic [4:0] Q_SA     = 5'd7;
  localparam logic [4:0] Q_SB     = 5'd8;
  localparam logic [4:0] Q_DA     = 5'd9;
  localparam logic [4:0] Q_DB     = 5'd10;
  localparam logic [4:0] Q_LIFT   = 5'd11;
  localparam logic [4:0] Q_LIFTW  = 5'd12;
  localparam logic [4:0] Q_CMP    = 5'd13;
  localparam logic [4:0] Q_UPA    = 5'd14;
  localparam logic [4:0] Q_UPB    = 5'd15;
  localparam logic [4:0] Q_UPC    = 5'd16;
  localparam logic [4:0] Q_PAR    = 5'd17;
  localparam logic [4:0] Q_PARW   = 5'd18;
  localparam logic [4:0] Q_DRD    = 5'd19;
  localparam logic [4:0] Q_DEP    = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  // Memories
  logic [NW-1:0]    s2n_mem   [0:MAX_STRINGS-1];
  logic [NW-1:0]    dep_mem   [0:MAX_STRINGS-1];
  logic [NW-1:0]    child_mem [0:(1<<(NW+AW))-1];
  logic [NW+AW-1:0] info_mem  [0:MAX_STRINGS-1];

  logic [NW-1:0]    s2n_q, dep_q, child_q;
  logic [NW+AW-1:0] info_q;
  logic             s2n_zero_r, dep_zero_r;

  // Control and working registers
  logic [4:0]      state_r;
  logic [CW-1:0]   sc_r, nc_r;
  logic [NW-1:0]   a_r, b_r, ta_r, pnode_r, pdep_r, da_r, cur_r, new_r;
  logic [AW-1:0]   lt_r;
  logic [LCW-1:0]  lvl_r;
  logic [NW-1:0]   diff_r;
  logic [IDX_W-1:0] sb_r;

  // Memory ports
  logic [NW-1:0]    s2n_ra, dep_ra, child_ra_node, info_ra;
  logic [AW-1:0]    child_ra_lt;
  logic             wr_new, wr_s2n;
  logic [NW-1:0]    s2n_wd;
  logic [NW-1:0]    anc_rnode, anc_wdata, anc_wnode, anc_rdata;
  logic [LW-1:0]    anc_rlvl, anc_wlvl;
  logic             anc_we;

  // Decoded input and read values
  logic [XW-1:0]        par_x, sa_x, sb_x, sbr_x, sc_x;
  logic [LETTER_W-1:0]  lt_off;
  logic                 lt_bad;
  logic [NW-1:0]        s2n_v, dep_v;
  logic [CW-1:0]        child_x;

  assign par_x  = XW'(parent_string);
  assign sa_x   = XW'(first_string);
  assign sb_x   = XW'(second_string);
  assign sbr_x  = XW'(sb_r);
  assign sc_x   = XW'(sc_r);
  assign lt_off = letter - LETTER_BASE;
  assign lt_bad = (letter < LETTER_BASE) || (lt_off >= LETTER_W'(ALPHABET));
  assign s2n_v  = s2n_zero_r ? '0 : s2n_q;
  assign dep_v  = dep_zero_r ? '0 : dep_q;
  assign child_x = CW'(child_q);
  assign idle   = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // Read addresses for the state that issues each read
  always_comb begin
    s2n_ra        = sbr_x[NW-1:0];
    dep_ra        = a_r;
    child_ra_node = s2n_v;
    child_ra_lt   = lt_r;
    info_ra       = child_q;
    anc_rnode     = cur_r;
    anc_rlvl      = LW'(lvl_r - LCW'(1));
    case (state_r)
      S_IDLE:  s2n_ra = (op == OP_QUERY) ? sa_x[NW-1:0] : par_x[NW-1:0];
      I_S2N:   dep_ra = s2n_v;
      I_CHILD: dep_ra = child_q;
      Q_SB:    dep_ra = a_r;
      Q_DA:    dep_ra = b_r;
      Q_LIFT:  begin
        anc_rnode = b_r;
        anc_rlvl  = lvl_r[LW-1:0];
      end
      Q_UPA:   begin
        anc_rnode = a_r;
        anc_rlvl  = lvl_r[LW-1:0];
      end
      Q_UPB:   begin
        anc_rnode = b_r;
        anc_rlvl  = lvl_r[LW-1:0];
      end
      Q_PAR:   begin
        anc_rnode = a_r;
        anc_rlvl  = '0;
      end
      default: begin
      end
    endcase
  end

  // Write enables and data
  assign wr_new = (state_r == I_NEW);
  assign wr_s2n = wr_new || ((state_r == I_INFO) && (info_q == {pnode_r, lt_r}));
  assign s2n_wd = wr_new ? nc_r[NW-1:0] : cur_r;

  always_comb begin
    anc_we    = 1'b0;
    anc_wnode = new_r;
    anc_wlvl  = lvl_r[LW-1:0];
    anc_wdata = anc_rdata;
    if (wr_new) begin
      anc_we    = 1'b1;
      anc_wnode = nc_r[NW-1:0];
      anc_wlvl  = '0;
      anc_wdata = pnode_r;
    end else if (state_r == I_FWR) begin
      anc_we = 1'b1;
    end
  end

  // Memory arrays: one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_s2n) begin
      s2n_mem[sc_r[NW-1:0]] <= s2n_wd;
    end
    if (wr_new) begin
      dep_mem[nc_r[NW-1:0]]          <= pdep_r + NW'(1);
      info_mem[nc_r[NW-1:0]]         <= {pnode_r, lt_r};
      child_mem[{pnode_r, lt_r}]     <= nc_r[NW-1:0];
    end
    s2n_q      <= s2n_mem[s2n_ra];
    s2n_zero_r <= (s2n_ra == '0);
    dep_q      <= dep_mem[dep_ra];
    dep_zero_r <= (dep_ra == '0);
    child_q    <= child_mem[{child_ra_node, child_ra_lt}];
    info_q     <= info_mem[info_ra];
  end

  tlpd_anc #(
    .NW (NW),
    .LW (LW)
  ) u_anc (
    .clk   (clk),
    .we    (anc_we),
    .wnode (anc_wnode),
    .wlvl  (anc_wlvl),
    .wdata (anc_wdata),
    .rnode (anc_rnode),
    .rlvl  (anc_rlvl),
    .rdata (anc_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sc_r    <= CW'(1);
      nc_r    <= CW'(1);
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            sb_r <= second_string;
            lt_r <= lt_off[AW-1:0];
            if (op == OP_INSERT) begin
              if (sc_r == CW'(MAX_STRINGS)) begin
                res     <= '{kind: op, depth: '0, index: '0, status: ST_FULL};
                state_r <= S_DONE;
              end else if ((par_x >= sc_x) || lt_bad) begin
                res     <= '{kind: op, depth: '0, index: '0, status: ST_UNDEFINED};
                state_r <= S_DONE;
              end else begin
                res     <= '{kind: op, depth: '0, index: '0, status: ST_OK};
                state_r <= I_S2N;
              end
            end else begin
              if ((sa_x >= sc_x) || (sb_x >= sc_x)) begin
                res     <= '{kind: op, depth: '0, index: '0, status: ST_UNDEFINED};
                state_r <= S_DONE;
              end else begin
                res     <= '{kind: op, depth: '0, index: '0, status: ST_OK};
                state_r <= Q_SA;
              end
            end
          end
        end
        I_S2N: begin
          pnode_r <= s2n_v;
          state_r <= I_CHILD;
        end
        I_CHILD: begin
          pdep_r <= dep_v;
          cur_r  <= child_q;
          if ((child_q != '0) && (child_x < nc_r)) begin
            state_r <= I_INFO;
          end else begin
            state_r <= I_NEW;
          end
        end
        I_INFO: begin
          // A stored child only counts if that node names this parent and letter.
          if (info_q == {pnode_r, lt_r}) begin
            res.depth  <= IDX_W'(dep_q);
            res.index  <= IDX_W'(sc_r);
            sc_r       <= sc_r + CW'(1);
            state_r    <= S_DONE;
          end else begin
            state_r <= I_NEW;
          end
        end
        I_NEW: begin
          res.depth <= IDX_W'(pdep_r + NW'(1));
          res.index <= IDX_W'(sc_r);
          new_r     <= nc_r[NW-1:0];
          cur_r     <= pnode_r;
          lvl_r     <= LCW'(1);
          sc_r      <= sc_r + CW'(1);
          nc_r      <= nc_r + CW'(1);
          state_r   <= (LOG_LEVELS == 1) ? S_DONE : I_FRD;
        end
        I_FRD: begin
          state_r <= I_FWR;
        end
        I_FWR: begin
          cur_r <= anc_rdata;
          lvl_r <= lvl_r + LCW'(1);
          if (lvl_r == LCW'(LOG_LEVELS - 1)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= I_FRD;
          end
        end
        Q_SA: begin
          a_r     <= s2n_v;
          state_r <= Q_SB;
        end
        Q_SB: begin
          b_r     <= s2n_v;
          state_r <= Q_DA;
        end
        Q_DA: begin
          da_r    <= dep_v;
          state_r <= Q_DB;
        end
        Q_DB: begin
          // Keep the deeper node in b.
          if (da_r > dep_v) begin
            a_r    <= b_r;
            b_r    <= a_r;
            diff_r <= da_r - dep_v;
          end else begin
            diff_r <= dep_v - da_r;
          end
          lvl_r   <= '0;
          state_r <= Q_LIFT;
        end
        Q_LIFT: begin
          if (lvl_r == LCW'(LOG_LEVELS)) begin
            state_r <= Q_CMP;
          end else if (diff_r[0]) begin
            state_r <= Q_LIFTW;
          end else begin
            diff_r <= diff_r >> 1;
            lvl_r  <= lvl_r + LCW'(1);
          end
        end
        Q_LIFTW: begin
          b_r     <= anc_rdata;
          diff_r  <= diff_r >> 1;
          lvl_r   <= lvl_r + LCW'(1);
          state_r <= Q_LIFT;
        end
        Q_CMP: begin
          lvl_r   <= LCW'(LOG_LEVELS - 1);
          state_r <= (a_r == b_r) ? Q_DRD : Q_UPA;
        end
        Q_UPA: begin
          state_r <= Q_UPB;
        end
        Q_UPB: begin
          ta_r    <= anc_rdata;
          state_r <= Q_UPC;
        end
        Q_UPC: begin
          if (ta_r != anc_rdata) begin
            a_r <= ta_r;
            b_r <= anc_rdata;
          end
          if (lvl_r == '0) begin
            state_r <= Q_PAR;
          end else begin
            lvl_r   <= lvl_r - LCW'(1);
            state_r <= Q_UPA;
          end
        end
        Q_PAR: begin
          state_r <= Q_PARW;
        end
        Q_PARW: begin
          a_r     <= anc_rdata;
          state_r <= Q_DRD;
        end
        Q_DRD: begin
          state_r <= Q_DEP;
        end
        Q_DEP: begin
          res.depth <= IDX_W'(dep_v);
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the counters
  a_nodes_le_strings : assert property (@(posedge clk) disable iff (!rst_n)
    nc_r <= sc_r) else $error("node count above string count");

  a_strings_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= CW'(MAX_STRINGS)) else $error("string count above table size");

  a_strings_step : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sc_r == $past(sc_r)) || (sc_r == $past(sc_r) + CW'(1)))
    else $error("string count moved by more than one");

endmodule

`default_nettype wire

// ===== hdl/trie_lca_prefix_depth.sv =====
// From an accepted input beat to its result beat: a rejected item goes straight to its
// result; an insert reads the parent node and its child, and one that adds a node then
// fills its ancestor row level by level; a query lifts the deeper node through every
// level, reading once more per set bit of the depth difference, then descends unless
// the nodes meet after lifting. One item in work at a time; the next beat is taken once
// the result has left the sequencer. Reset: synchronous, active low, control only.
// ============================================================================
// trie_lca_prefix_depth
// Trie of strings with binary-lifting common ancestor queries, stream ports.
// ============================================================================
`default_nettype none

module trie_lca_prefix_depth
  import tlpd_pkg::*;
#(
  parameter int MAX_STRINGS = DEF_MAX_STRINGS,
  parameter int LOG_LEVELS  = DEF_LOG_LEVELS,
  parameter int ALPHABET    = DEF_ALPHABET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // parent_string[11:0], letter[18:12], first_string[30:19], second_string[42:31]
  input  wire logic [47:0] in_tdata,
  // operation[0]
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // depth[11:0], string_index[23:12], status[25:24]
  output logic [31:0]      out_tdata,
  // result_kind[0]
  output logic [0:0]       out_tuser
);

  logic      idle, res_valid, res_ready, out_valid_r;
  tlpd_res_t res, out_r;

  assign in_tready = idle;

  tlpd_ctrl #(
    .MAX_STRINGS (MAX_STRINGS),
    .LOG_LEVELS  (LOG_LEVELS),
    .ALPHABET    (ALPHABET)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (in_tvalid),
    .idle          (idle),
    .op            (in_tuser[0]),
    .parent_string (in_tdata[11:0]),
    .letter        (in_tdata[18:12]),
    .first_string  (in_tdata[30:19]),
    .second_string (in_tdata[42:31]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // Output register: takes a beat whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.status, out_r.index, out_r.depth};
  assign out_tuser  = out_r.kind;

endmodule

`default_nettype wire

// ===== verif/trie_lca_prefix_depth_tb.sv =====
// ============================================================================
// trie_lca_prefix_depth_tb
// Self-checking bench for the trie prefix depth block: a directed table
// followed by random inserts and queries, each result checked against a
// behavioural trie kept inside the bench.
// ============================================================================
`timescale 1ns / 1ps

module trie_lca_prefix_depth_tb;
  import tlpd_pkg::*;

  localparam int NSTR = DEF_MAX_STRINGS;
  localparam int NLEV = DEF_LOG_LEVELS;
  localparam int NABC = DEF_ALPHABET;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  depth;
    logic [IDX_W-1:0]  index;
    logic [STAT_W-1:0] status;
  } answer_t;

  typedef struct {
    logic                op;
    logic [IDX_W-1:0]    parent;
    logic [LETTER_W-1:0] letter;
    logic [IDX_W-1:0]    sa;
    logic [IDX_W-1:0]    sb;
    bit                  fixed;
    answer_t             want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  trie_lca_prefix_depth uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // Behavioural copy of the trie
  int unsigned str_node [NSTR];
  int unsigned nd_depth [NSTR];
  int unsigned kids     [NSTR*NABC];
  int unsigned jump     [NSTR*NLEV];
  int unsigned n_nodes, n_strings;

  answer_t pending_answers [$];
  int      errors = 0;
  int      send_idle = 0, recv_idle = 0;
  bit      hold_recv = 1'b0;

  function automatic void trie_clear();
    foreach (str_node[i]) begin str_node[i] = 0; nd_depth[i] = 0; end
    foreach (kids[i]) kids[i] = 0;
    foreach (jump[i]) jump[i] = 0;
    n_nodes = 1;
    n_strings = 1;
  endfunction

  function automatic answer_t trie_apply(logic op, int unsigned par, int unsigned ltr,
                                         int unsigned sa, int unsigned sb);
    answer_t r;
    int unsigned pn, slot, nd, a, b, t, diff;
    r = '0;
    r.kind = op;
    if (op == OP_INSERT) begin
      if (n_strings >= NSTR) begin
        r.status = ST_FULL;
      end else if (par >= n_strings || ltr < LETTER_BASE || ltr - LETTER_BASE >= NABC) begin
        r.status = ST_UNDEFINED;
      end else begin
        pn = str_node[par];
        slot = pn*NABC + (ltr - LETTER_BASE);
        nd = kids[slot];
        if (nd == 0) begin
          nd = n_nodes++;
          nd_depth[nd] = nd_depth[pn] + 1;
          for (int i = 0; i < NABC; i++) kids[nd*NABC+i] = 0;
          jump[nd*NLEV] = pn;
          for (int i = 1; i < NLEV; i++)
            jump[nd*NLEV+i] = jump[jump[nd*NLEV+i-1]*NLEV+i-1];
          kids[slot] = nd;
        end
        str_node[n_strings] = nd;
        r.depth = IDX_W'(nd_depth[nd]);
        r.index = IDX_W'(n_strings);
        r.status = ST_OK;
        n_strings++;
      end
    end else if (sa >= n_strings || sb >= n_strings) begin
      r.status = ST_UNDEFINED;
    end else begin
      a = str_node[sa];
      b = str_node[sb];
      if (nd_depth[a] > nd_depth[b]) begin t = a; a = b; b = t; end
      diff = nd_depth[b] - nd_depth[a];
      for (int i = 0; i < NLEV; i++)
        if ((diff >> i) & 1) b = jump[b*NLEV+i];
      if (a != b) begin
        for (int i = NLEV-1; i >= 0; i--)
          if (jump[a*NLEV+i] != jump[b*NLEV+i]) begin
            a = jump[a*NLEV+i];
            b = jump[b*NLEV+i];
          end
        a = jump[a*NLEV];
      end
      r.depth = IDX_W'(nd_depth[a]);
      r.status = ST_OK;
    end
    return r;
  endfunction

  // Offer one beat and wait for its acceptance
  task automatic send_item(row_t it);
    answer_t got;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {5'b0, it.sb, it.sa, it.letter, it.parent};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = trie_apply(it.op, it.parent, it.letter, it.sa, it.sb);
    if (it.fixed && got != it.want) begin
      $display("%0t table row disagrees: expected %h, predicted %h", $time, it.want, got);
      errors++;
    end
    pending_answers.insert(pending_answers.size(), got);
  endtask

  task automatic lift_valid();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    lift_valid();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic row_t mk(logic op, int unsigned p, int unsigned l,
                              int unsigned a, int unsigned b);
    row_t r;
    r.op = op; r.parent = IDX_W'(p); r.letter = LETTER_W'(l);
    r.sa = IDX_W'(a); r.sb = IDX_W'(b);
    r.fixed = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mkx(row_t r, answer_t w);
    r.fixed = 1; r.want = w;
    return r;
  endfunction

  // Random strings mostly extend recent ones, so chains grow deep
  function automatic row_t rand_item();
    int unsigned k, p;
    k = $urandom_range(99);
    p = (n_strings > 40 && $urandom_range(1)) ?
        $urandom_range(n_strings-1, n_strings-40) : $urandom_range(n_strings-1);
    if (k < 45)
      return mk(OP_INSERT, p, LETTER_BASE + $urandom_range(k < 20 ? 2 : NABC-1),
                $urandom, $urandom);
    if (k < 90)
      return mk(OP_QUERY, $urandom, $urandom, $urandom_range(n_strings-1),
                $urandom_range(n_strings-1));
    if (k < 95)
      return mk(OP_INSERT, $urandom, $urandom, $urandom, $urandom);
    return mk(OP_QUERY, $urandom, $urandom, $urandom, $urandom_range(n_strings+3));
  endfunction

  // Result side: random back-pressure and comparison
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[11:0], out_tdata[23:12], out_tdata[25:24]};
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result beat: actual %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.kind != want.kind || got.depth != want.depth ||
            got.index != want.index || got.status != want.status) begin
          $display({"%0t mismatch: expected kind %0d depth %0d index %0d status %0d,",
                    " actual kind %0d depth %0d index %0d status %0d"},
                   $time, want.kind, want.depth, want.index, want.status,
                   got.kind, got.depth, got.index, got.status);
          errors++;
        end
      end
    end
    out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #100ms;
    $display("FAIL trie_lca_prefix_depth");
    $finish;
  end

  initial begin
    row_t tbl [$];
    answer_t w;
    int n;
    trie_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    w = '0; w.kind = OP_QUERY;
    tbl.insert(tbl.size(), mkx(mk(OP_QUERY, 0, 0, 0, 0), w));
    w.status = ST_UNDEFINED;
    tbl.insert(tbl.size(), mkx(mk(OP_QUERY, 0, 0, 4095, 0), w));
    tbl.insert(tbl.size(), mkx(mk(OP_QUERY, 0, 0, 0, 1), w));
    w = '0; w.status = ST_UNDEFINED;
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 1, 8'h61, 0, 0), w));
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 0, 8'h60, 0, 0), w));
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 0, 8'h7b, 0, 0), w));
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 0, 8'h00, 0, 0), w));
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 4095, 8'h7f, 4095, 4095), w));
    w = '0; w.depth = 1; w.index = 1;
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 0, 8'h61, 0, 0), w));
    w.index = 2;
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 0, 8'h7a, 0, 0), w));
    w.index = 3;
    tbl.insert(tbl.size(), mkx(mk(OP_INSERT, 0, 8'h61, 0, 0), w));
    tbl.insert(tbl.size(), mk(OP_INSERT, 1, 8'h62, 0, 0));
    tbl.insert(tbl.size(), mk(OP_INSERT, 4, 8'h63, 0, 0));
    tbl.insert(tbl.size(), mk(OP_INSERT, 1, 8'h7a, 0, 0));
    tbl.insert(tbl.size(), mk(OP_QUERY, 0, 0, 5, 6));
    tbl.insert(tbl.size(), mk(OP_QUERY, 0, 0, 4, 6));
    tbl.insert(tbl.size(), mk(OP_QUERY, 0, 0, 1, 3));
    tbl.insert(tbl.size(), mk(OP_QUERY, 0, 0, 5, 2));
    tbl.insert(tbl.size(), mk(OP_QUERY, 0, 0, 0, 5));
    tbl.insert(tbl.size(), mk(OP_QUERY, 0, 0, 5, 1));
    foreach (tbl[i]) send_item(tbl[i]);

    // Long receiver hold-off so the block fills and stalls its input
    fork
      begin hold_recv = 1'b1; repeat (400) @(posedge clk); hold_recv = 1'b0; end
      repeat (6) send_item(rand_item());
    join
    drain();

    // Random phases with changing idle ratios
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 69 : 0;
      recv_idle = (ph == 0) ? 69 : (ph == 1) ? 30 : 0;
      n = (ph == 2) ? 600 : 200;
      for (int i = 0; i < n; i++) send_item(rand_item());
      drain();
    end

    // Queries on the highest string indices
    send_idle = 0; recv_idle = 0;
    send_item(mk(OP_QUERY, 0, 0, 4095, 4094));
    send_item(mk(OP_QUERY, 0, 0, 4095, 0));
    send_item(mk(OP_QUERY, 0, 0, 4095, 4095));
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0 && pending_answers.size() == 0)
      $display("PASS trie_lca_prefix_depth");
    else
      $display("FAIL trie_lca_prefix_depth");
    $finish;
  end

endmodule
